[hdl/i2cmbe_pkg.sv]
package i2cmbe_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    localparam int TPU_W   = 10;
    localparam int DELAY_W = 12;
    localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(50);

    // Command kinds; the opcode of a beat uses the same codes, zero being a plain tick.
    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    // Sequencer phases; their meaning depends on the command kind.
    localparam logic [3:0] PH_0 = 4'd0;
    localparam logic [3:0] PH_1 = 4'd1;
    localparam logic [3:0] PH_2 = 4'd2;
    localparam logic [3:0] PH_3 = 4'd3;
    localparam logic [3:0] PH_4 = 4'd4;
    localparam logic [3:0] PH_5 = 4'd5;

    typedef struct packed {
        kind_t                  kind;
        logic [3:0]             phase;
        logic [BIT_IDX_W-1:0]   bit_idx;
        logic [7:0]             shift;
        logic [DELAY_W-1:0]     delay;
        logic                   scl;
        logic                   sda;
        logic                   ack_hold;
        logic [7:0]             last_read;
        logic                   last_ack;
    } seq_state_t;

    localparam seq_state_t SEQ_RESET = '{
        kind: KIND_IDLE, phase: PH_0, bit_idx: '0, shift: '0, delay: '0,
        scl: 1'b1, sda: 1'b1, ack_hold: 1'b1, last_read: '0, last_ack: 1'b1
    };

endpackage

[hdl/i2cmbe_step.sv]
module i2cmbe_step (
    input  i2cmbe_pkg::seq_state_t       cur,
    input  logic [2:0]                   opcode,
    input  logic [7:0]                   write_data,
    input  logic                         ack_to_send,
    input  logic                         sda_in,
    input  logic [i2cmbe_pkg::TPU_W-1:0] ticks_per_us,
    output i2cmbe_pkg::seq_state_t       nxt,
    output logic                         done
);

    i2cmbe_pkg::seq_state_t             pre;
    logic                               run;
    logic [i2cmbe_pkg::DELAY_W-1:0]     d1;
    logic [i2cmbe_pkg::DELAY_W-1:0]     d3;

    // A zero unit still waits one tick. Three units of at most 1023 ticks stay below
    // the 4095-tick counter limit, so no saturation logic is needed.
    always_comb begin
        if (ticks_per_us == '0) begin
            d1 = i2cmbe_pkg::DELAY_W'(1);
            d3 = i2cmbe_pkg::DELAY_W'(1);
        end else begin
            d1 = i2cmbe_pkg::DELAY_W'(ticks_per_us);
            d3 = i2cmbe_pkg::DELAY_W'(ticks_per_us)
               + {i2cmbe_pkg::DELAY_W'(ticks_per_us) << 1};
        end
    end

    always_comb begin
        pre  = cur;
        run  = 1'b0;
        done = 1'b0;
        if (cur.kind == i2cmbe_pkg::KIND_IDLE) begin
            if (opcode == i2cmbe_pkg::KIND_START || opcode == i2cmbe_pkg::KIND_STOP ||
                opcode == i2cmbe_pkg::KIND_WRITE || opcode == i2cmbe_pkg::KIND_READ) begin
                pre.kind    = i2cmbe_pkg::kind_t'(opcode);
                pre.phase   = i2cmbe_pkg::PH_0;
                pre.bit_idx = '0;
                pre.delay   = '0;
                if (opcode == i2cmbe_pkg::KIND_WRITE) begin
                    pre.shift = write_data;
                end
                if (opcode == i2cmbe_pkg::KIND_READ) begin
                    pre.shift    = '0;
                    pre.ack_hold = ack_to_send;
                end
                run = 1'b1;
            end
        end else begin
            if (cur.delay != '0) begin
                pre.delay = cur.delay - 1'b1;
            end
            run = (pre.delay == '0);
        end

        nxt = pre;
        if (run) begin
            unique case (pre.kind)
                i2cmbe_pkg::KIND_START: begin
                    case (pre.phase)
                        i2cmbe_pkg::PH_0: begin
                            nxt.scl = 1'b1; nxt.sda = 1'b1;
                            nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_1;
                        end
                        i2cmbe_pkg::PH_1: begin
                            nxt.sda = 1'b0; nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_2;
                        end
                        i2cmbe_pkg::PH_2: begin
                            nxt.scl = 1'b0; nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_3;
                        end
                        default: begin
                            nxt.scl = 1'b0; nxt.kind = i2cmbe_pkg::KIND_IDLE;
                            nxt.phase = i2cmbe_pkg::PH_0; nxt.delay = '0; done = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::KIND_STOP: begin
                    case (pre.phase)
                        i2cmbe_pkg::PH_0: begin
                            nxt.scl = 1'b0; nxt.sda = 1'b0;
                            nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_1;
                        end
                        i2cmbe_pkg::PH_1: begin
                            nxt.scl = 1'b1; nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_2;
                        end
                        i2cmbe_pkg::PH_2: begin
                            nxt.sda = 1'b1; nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_3;
                        end
                        default: begin
                            // Stop leaves SCL released at the end.
                            nxt.kind = i2cmbe_pkg::KIND_IDLE;
                            nxt.phase = i2cmbe_pkg::PH_0; nxt.delay = '0; done = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::KIND_WRITE: begin
                    case (pre.phase)
                        i2cmbe_pkg::PH_0: begin
                            nxt.scl = 1'b0;
                            nxt.sda = pre.shift[~pre.bit_idx];
                            nxt.delay = d3; nxt.phase = i2cmbe_pkg::PH_1;
                        end
                        i2cmbe_pkg::PH_1: begin
                            nxt.scl = 1'b1;
                            nxt.delay = d3;
                            if (pre.bit_idx < i2cmbe_pkg::LAST_BIT) begin
                                nxt.bit_idx = pre.bit_idx + 1'b1;
                                nxt.phase = i2cmbe_pkg::PH_0;
                            end else begin
                                nxt.phase = i2cmbe_pkg::PH_2;
                            end
                        end
                        i2cmbe_pkg::PH_2: begin
                            nxt.scl = 1'b0; nxt.sda = 1'b1;
                            nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_3;
                        end
                        i2cmbe_pkg::PH_3: begin
                            nxt.scl = 1'b1; nxt.last_ack = sda_in;
                            nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_4;
                        end
                        default: begin
                            nxt.scl = 1'b0; nxt.kind = i2cmbe_pkg::KIND_IDLE;
                            nxt.phase = i2cmbe_pkg::PH_0; nxt.delay = '0; done = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::KIND_READ: begin
                    case (pre.phase)
                        i2cmbe_pkg::PH_0: begin
                            nxt.sda = 1'b1; nxt.scl = 1'b1;
                            nxt.delay = d3; nxt.phase = i2cmbe_pkg::PH_1;
                        end
                        i2cmbe_pkg::PH_1: begin
                            nxt.shift = {pre.shift[6:0], sda_in};
                            nxt.scl = 1'b0;
                            nxt.delay = d3;
                            if (pre.bit_idx < i2cmbe_pkg::LAST_BIT) begin
                                nxt.bit_idx = pre.bit_idx + 1'b1;
                                nxt.phase = i2cmbe_pkg::PH_2;
                            end else begin
                                nxt.phase = i2cmbe_pkg::PH_3;
                            end
                        end
                        i2cmbe_pkg::PH_2: begin
                            nxt.scl = 1'b1; nxt.delay = d3; nxt.phase = i2cmbe_pkg::PH_1;
                        end
                        i2cmbe_pkg::PH_3: begin
                            nxt.sda = pre.ack_hold; nxt.delay = d1;
                            nxt.phase = i2cmbe_pkg::PH_4;
                        end
                        i2cmbe_pkg::PH_4: begin
                            nxt.scl = 1'b1; nxt.delay = d1; nxt.phase = i2cmbe_pkg::PH_5;
                        end
                        default: begin
                            nxt.last_read = pre.shift;
                            nxt.scl = 1'b0; nxt.kind = i2cmbe_pkg::KIND_IDLE;
                            nxt.phase = i2cmbe_pkg::PH_0; nxt.delay = '0; done = 1'b1;
                        end
                    endcase
                end
                default: begin
                    nxt.kind = i2cmbe_pkg::KIND_IDLE;
                    nxt.phase = i2cmbe_pkg::PH_0;
                    nxt.delay = '0;
                end
            endcase
        end
    end

endmodule

[hdl/i2c_master_byte_engine.sv]
// Bit-banged I2C master sequencer. Every input beat is one tick of the bus timebase and
// carries an opcode (tick, start, stop, write byte, read byte), the byte to write, the
// ack level to send after a read and the sampled SDA level. Commands are taken only
// while the engine is idle; otherwise the opcode acts as a plain tick. Every input beat
// yields exactly one output beat with the driven SCL/SDA levels, the busy flag, the last
// read byte and the last sampled acknowledge; m_tlast marks the tick that finished a
// command. The engine sustains one beat per clock unless m_tready stalls it: the whole
// sequencer step is one pass of short combinational logic between the state register and the
// output register, which accepts a new beat in the same cycle its previous beat is taken.
// Output beats are registered and appear the cycle after their input beats. The user must write the
// delay unit (ticks_per_us, reset 50) through the cfg channel only while no beat is in flight; the
// block does not enforce it. A new value applies from the next delay load; zero gives one-tick delays.
module i2c_master_byte_engine (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,       // ticks_per_us

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [7:0] write_data, [8] ack_to_send, [9] sda_in
    input  logic [2:0]  s_tuser,        // [2:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // [0] scl_level, [1] sda_level, [2] busy_res,
                                        // [10:3] read_data, [11] ack_seen
    output logic        m_tlast         // done_res
);

    logic [i2cmbe_pkg::TPU_W-1:0] tpu_reg;
    i2cmbe_pkg::seq_state_t       state_reg;
    i2cmbe_pkg::seq_state_t       state_next;
    logic                         step_done;
    logic                         in_acc;

    logic                         m_tvalid_reg;
    logic [15:0]                  m_tdata_reg;
    logic                         m_tlast_reg;

    // The delay register is always writable; a new value applies from the next delay load.
    assign cfg_ready = 1'b1;

    // A new beat enters whenever the output register is empty or is being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    i2cmbe_step u_step (
        .cur          (state_reg),
        .opcode       (s_tuser),
        .write_data   (s_tdata[7:0]),
        .ack_to_send  (s_tdata[8]),
        .sda_in       (s_tdata[9]),
        .ticks_per_us (tpu_reg),
        .nxt          (state_next),
        .done         (step_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= i2cmbe_pkg::TPU_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tpu_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= i2cmbe_pkg::SEQ_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload needs no reset; it is qualified by m_tvalid.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            m_tdata_reg <= {4'b0, state_next.last_ack, state_next.last_read,
                            (state_next.kind != i2cmbe_pkg::KIND_IDLE),
                            state_next.sda, state_next.scl};
            m_tlast_reg <= step_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // An idle sequencer never holds a pending delay.
    a_idle_no_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.kind == i2cmbe_pkg::KIND_IDLE) |-> (state_reg.delay == '0))
        else $error("idle sequencer holds a delay count");

    // A beat that finishes a command never reports busy.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg) |-> !m_tdata_reg[2])
        else $error("finished command still reported busy");

    // While busy with more than one tick to wait, each beat counts the delay down by one.
    a_delay_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && state_reg.kind != i2cmbe_pkg::KIND_IDLE && state_reg.delay > 1)
        |=> (state_reg.delay == $past(state_reg.delay) - 1'b1))
        else $error("delay counter did not count down");

    // A write command accepted while idle starts the write sequence.
    a_write_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && state_reg.kind == i2cmbe_pkg::KIND_IDLE &&
         s_tuser == i2cmbe_pkg::KIND_WRITE)
        |=> (state_reg.kind == i2cmbe_pkg::KIND_WRITE))
        else $error("write command not started");

endmodule

[tb/testbench.sv]
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Checks the byte engine of a bit-banged I2C master from its stream ports.
    // Every input beat is one tick of the bus timebase, and each accepted beat
    // runs through a sequencer model kept in this module. The model produces the
    // SCL/SDA levels, the busy and done flags, the last read byte and the last
    // sampled acknowledge. Each output beat is compared against the oldest
    // prediction. Both stream sides idle at random. The delay unit is rewritten
    // between phases, and each time the sender first holds off until every
    // predicted beat has come back.

    // Opcode zero is a plain tick. Codes above the read command are spare
    // and act as a tick as well.
    localparam logic [2:0] OP_TICK      = i2cmbe_pkg::KIND_IDLE;
    localparam logic [2:0] OP_SPARE_MIN = 3'd5;
    localparam logic [2:0] OP_SPARE_MAX = 3'd7;

    localparam logic [i2cmbe_pkg::TPU_W-1:0]   TPU_LONG  = 10'd300;
    localparam logic [i2cmbe_pkg::DELAY_W-1:0] DELAY_SAT = '1;
    localparam int MAX_WAIT    = 17;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int TAIL_CYCLES  = 8;

    // One output beat, split into its fields.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack_seen;
    } bus_levels_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [i2cmbe_pkg::TPU_W-1:0]    cfg_data  = '0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] write_data, [8] ack_to_send, [9] sda_in
    logic [2:0]  s_tuser  = '0;     // [2:0] opcode

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] scl, [1] sda, [2] busy, [10:3] read_data, [11] ack
    logic        m_tlast;           // done

    i2c_master_byte_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sequencer model. These variables mirror the engine state after the
    // last accepted input beat.
    // ------------------------------------------------------------------
    logic [i2cmbe_pkg::TPU_W-1:0]     tpu_model     = i2cmbe_pkg::TPU_RESET;
    i2cmbe_pkg::kind_t                eng_kind      = i2cmbe_pkg::KIND_IDLE;
    logic [3:0]                       eng_phase     = i2cmbe_pkg::PH_0;
    logic [i2cmbe_pkg::BIT_IDX_W-1:0] eng_bit       = '0;
    logic [7:0]                       eng_shift     = '0;
    logic [i2cmbe_pkg::DELAY_W-1:0]   eng_delay     = '0;
    logic                             eng_scl       = 1'b1;
    logic                             eng_sda       = 1'b1;
    logic                             eng_ack_hold  = 1'b1;
    logic [7:0]                       eng_last_read = '0;
    logic                             eng_last_ack  = 1'b1;
    logic                             eng_done      = 1'b0;

    bus_levels_t expected_levels[$];

    // Run bookkeeping.
    int  beats_sent      = 0;
    int  beats_checked   = 0;
    int  commands_done   = 0;
    int  tpu_settings    = 0;
    int  mismatches      = 0;
    int  orphan_beats    = 0;
    int  cycle_count     = 0;
    bit  sender_gaps_on  = 1'b1;
    bit  receiver_stalls = 1'b1;

    // A delay of units microseconds. A zero product still costs one tick and
    // a long one saturates at the counter's full scale.
    function automatic logic [i2cmbe_pkg::DELAY_W-1:0] delay_ticks(input int units);
        int v;
        v = units * int'(tpu_model);
        if (v == 0) v = 1;
        if (v > int'(DELAY_SAT)) v = int'(DELAY_SAT);
        return i2cmbe_pkg::DELAY_W'(v);
    endfunction

    function automatic void wait_then(input int units, input logic [3:0] nxt);
        eng_delay = delay_ticks(units);
        eng_phase = nxt;
    endfunction

    // Ends a command. The stop sequence leaves SCL released; the others end
    // with SCL pulled low.
    function automatic void close_command(input logic pull_scl);
        if (pull_scl) eng_scl = 1'b0;
        eng_kind  = i2cmbe_pkg::KIND_IDLE;
        eng_phase = i2cmbe_pkg::PH_0;
        eng_delay = '0;
        eng_done  = 1'b1;
    endfunction

    // One action of the current command. Phase numbers restart for every
    // command kind.
    function automatic void run_action(input logic sda_line);
        case (eng_kind)
            i2cmbe_pkg::KIND_START: begin
                case (eng_phase)
                    i2cmbe_pkg::PH_0: begin
                        eng_scl = 1'b1; eng_sda = 1'b1; wait_then(1, i2cmbe_pkg::PH_1);
                    end
                    i2cmbe_pkg::PH_1: begin eng_sda = 1'b0; wait_then(1, i2cmbe_pkg::PH_2); end
                    i2cmbe_pkg::PH_2: begin eng_scl = 1'b0; wait_then(1, i2cmbe_pkg::PH_3); end
                    default: close_command(1'b1);
                endcase
            end
            i2cmbe_pkg::KIND_STOP: begin
                case (eng_phase)
                    i2cmbe_pkg::PH_0: begin
                        eng_scl = 1'b0; eng_sda = 1'b0; wait_then(1, i2cmbe_pkg::PH_1);
                    end
                    i2cmbe_pkg::PH_1: begin eng_scl = 1'b1; wait_then(1, i2cmbe_pkg::PH_2); end
                    i2cmbe_pkg::PH_2: begin eng_sda = 1'b1; wait_then(1, i2cmbe_pkg::PH_3); end
                    default: close_command(1'b0);
                endcase
            end
            i2cmbe_pkg::KIND_WRITE: begin
                case (eng_phase)
                    i2cmbe_pkg::PH_0: begin
                        eng_scl = 1'b0;
                        eng_sda = eng_shift[i2cmbe_pkg::LAST_BIT - eng_bit];
                        wait_then(3, i2cmbe_pkg::PH_1);
                    end
                    i2cmbe_pkg::PH_1: begin
                        eng_scl = 1'b1;
                        if (eng_bit < i2cmbe_pkg::LAST_BIT) begin
                            eng_bit = eng_bit + 1'b1;
                            wait_then(3, i2cmbe_pkg::PH_0);
                        end else begin
                            wait_then(3, i2cmbe_pkg::PH_2);
                        end
                    end
                    i2cmbe_pkg::PH_2: begin
                        eng_scl = 1'b0; eng_sda = 1'b1; wait_then(1, i2cmbe_pkg::PH_3);
                    end
                    i2cmbe_pkg::PH_3: begin
                        eng_scl = 1'b1; eng_last_ack = sda_line;
                        wait_then(1, i2cmbe_pkg::PH_4);
                    end
                    default: close_command(1'b1);
                endcase
            end
            i2cmbe_pkg::KIND_READ: begin
                case (eng_phase)
                    i2cmbe_pkg::PH_0: begin
                        eng_sda = 1'b1; eng_scl = 1'b1; wait_then(3, i2cmbe_pkg::PH_1);
                    end
                    i2cmbe_pkg::PH_1: begin
                        eng_shift = {eng_shift[6:0], sda_line};
                        eng_scl   = 1'b0;
                        if (eng_bit < i2cmbe_pkg::LAST_BIT) begin
                            eng_bit = eng_bit + 1'b1;
                            wait_then(3, i2cmbe_pkg::PH_2);
                        end else begin
                            wait_then(3, i2cmbe_pkg::PH_3);
                        end
                    end
                    i2cmbe_pkg::PH_2: begin eng_scl = 1'b1; wait_then(3, i2cmbe_pkg::PH_1); end
                    i2cmbe_pkg::PH_3: begin
                        eng_sda = eng_ack_hold; wait_then(1, i2cmbe_pkg::PH_4);
                    end
                    i2cmbe_pkg::PH_4: begin eng_scl = 1'b1; wait_then(1, i2cmbe_pkg::PH_5); end
                    default: begin
                        eng_last_read = eng_shift;
                        close_command(1'b1);
                    end
                endcase
            end
            default: begin
                eng_kind  = i2cmbe_pkg::KIND_IDLE;
                eng_phase = i2cmbe_pkg::PH_0;
                eng_delay = '0;
            end
        endcase
    endfunction

    // Advances the model by one tick and returns the beat the engine should
    // emit for it. A command opcode only counts while the engine is idle.
    function automatic bus_levels_t advance_sequencer(input logic [2:0] op,
                                                      input logic [7:0] wdata,
                                                      input logic ack,
                                                      input logic sda_line);
        bus_levels_t lv;
        eng_done = 1'b0;
        if (eng_kind == i2cmbe_pkg::KIND_IDLE) begin
            if (op >= i2cmbe_pkg::KIND_START && op <= i2cmbe_pkg::KIND_READ) begin
                eng_kind  = i2cmbe_pkg::kind_t'(op);
                eng_phase = i2cmbe_pkg::PH_0;
                eng_bit   = '0;
                eng_delay = '0;
                if (op == i2cmbe_pkg::KIND_WRITE) eng_shift = wdata;
                if (op == i2cmbe_pkg::KIND_READ) begin
                    eng_shift    = '0;
                    eng_ack_hold = ack;
                end
                run_action(sda_line);
            end
        end else begin
            if (eng_delay != '0) eng_delay = eng_delay - 1'b1;
            if (eng_delay == '0) run_action(sda_line);
        end
        lv.scl       = eng_scl;
        lv.sda       = eng_sda;
        lv.busy      = (eng_kind != i2cmbe_pkg::KIND_IDLE);
        lv.done      = eng_done;
        lv.read_data = eng_last_read;
        lv.ack_seen  = eng_last_ack;
        return lv;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Every task is entered and left at a falling edge. Valid
    // stays high after a beat; the next call either reloads it with the
    // following beat or drops it for a gap, so it never toggles twice in
    // one step.
    // ------------------------------------------------------------------
    task automatic send_tick(input logic [2:0] op, input logic [7:0] wdata,
                             input logic ack, input logic sda_line);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, sda_line, ack, wdata};
        do @(posedge aclk); while (!s_tready);
        // The beat was taken at this edge; predict its output beat now.
        expected_levels.push_back(advance_sequencer(op, wdata, ack, sda_line));
        beats_sent++;
        @(negedge aclk);
    endtask

    // Keeps ticking until the model says the command has finished. Most
    // beats are plain ticks, but some carry a command or a spare opcode,
    // which the engine must ignore while busy. SDA is random throughout.
    task automatic finish_command();
        logic [2:0] op;
        while (eng_kind != i2cmbe_pkg::KIND_IDLE) begin
            op = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_TICK;
            send_tick(op, 8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic issue_command(input logic [2:0] op, input logic [7:0] wdata,
                                 input logic ack);
        send_tick(op, wdata, ack, 1'($urandom));
        finish_command();
    endtask

    // Holds the sender off until every predicted beat has been taken.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_levels.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes the delay unit once nothing is in flight on the stream.
    task automatic write_tpu(input logic [i2cmbe_pkg::TPU_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tpu_model = value;
        tpu_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: the receiver draws a stall before every beat it takes.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        @(negedge aclk);
        forever begin
            stall = receiver_stalls ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Compares each output beat taken with the oldest prediction.
    always @(posedge aclk) begin
        bus_levels_t got;
        bus_levels_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.scl       = m_tdata[0];
            got.sda       = m_tdata[1];
            got.busy      = m_tdata[2];
            got.done      = m_tlast;
            got.read_data = m_tdata[10:3];
            got.ack_seen  = m_tdata[11];
            if (expected_levels.size() == 0) begin
                if (mismatches + orphan_beats < 10)
                    $display("%0t: output beat with nothing predicted: %p", $realtime, got);
                orphan_beats++;
            end else begin
                want = expected_levels.pop_front();
                beats_checked++;
                if (want.done) commands_done++;
                if (got.scl !== want.scl || got.sda !== want.sda ||
                    got.busy !== want.busy || got.done !== want.done ||
                    got.read_data !== want.read_data || got.ack_seen !== want.ack_seen) begin
                    if (mismatches + orphan_beats < 10) begin
                        $display("%0t: beat %0d mismatch", $realtime, beats_checked);
                        $display("  expected scl=%b sda=%b busy=%b done=%b rdata=%h ack=%b",
                                 want.scl, want.sda, want.busy, want.done,
                                 want.read_data, want.ack_seen);
                        $display("  actual   scl=%b sda=%b busy=%b done=%b rdata=%h ack=%b",
                                 got.scl, got.sda, got.busy, got.done,
                                 got.read_data, got.ack_seen);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats still predicted",
                     cycle_count, expected_levels.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the delay unit is 50 ticks; a start sequence at that
    // setting confirms both the reset levels and the default timing.
    task automatic test_reset_delay();
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b1);
        issue_command(i2cmbe_pkg::KIND_START, 8'h00, 1'b0);
    endtask

    // Short directed pass with a zero delay unit, which must still give one
    // tick per action. Spare opcodes at idle do nothing, a command arriving
    // mid-write is ignored, and each command kind runs once.
    task automatic test_directed_commands();
        logic [2:0] op;
        write_tpu('0);
        for (op = OP_SPARE_MIN; op <= OP_SPARE_MAX && op != 3'd0; op++)
            send_tick(op, 8'hFF, 1'b1, 1'b0);
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0);
        issue_command(i2cmbe_pkg::KIND_START, 8'h00, 1'b0);
        send_tick(i2cmbe_pkg::KIND_WRITE, 8'h00, 1'b1, 1'b1);
        send_tick(i2cmbe_pkg::KIND_READ, 8'hFF, 1'b0, 1'b0);
        send_tick(i2cmbe_pkg::KIND_STOP, 8'hFF, 1'b1, 1'b1);
        finish_command();
        issue_command(i2cmbe_pkg::KIND_READ, 8'h00, 1'b1);
        issue_command(i2cmbe_pkg::KIND_STOP, 8'h00, 1'b0);
    endtask

    // Long delay unit: the first action of a start holds for the full count
    // before SDA falls. The unit is cut back a few ticks before that delay
    // runs out; the delay already loaded still counts out in full, and the
    // later actions use the short setting.
    task automatic test_long_delay();
        write_tpu(TPU_LONG);
        send_tick(i2cmbe_pkg::KIND_START, 8'h00, 1'b0, 1'b1);
        repeat (int'(TPU_LONG) - 4)
            send_tick(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
        write_tpu(i2cmbe_pkg::TPU_W'(1));
        finish_command();
    endtask

    // Random traffic. Most of it is well-formed transfers (start, a few
    // bytes written or read with random data and ack levels, stop); the rest
    // is loose beats with any opcode. The delay unit cycles through small
    // values and the idling on both sides switches on and off.
    task automatic test_random_traffic();
        int round_end;
        int n_bytes;
        for (int round = 0; round < 4; round++) begin
            write_tpu(i2cmbe_pkg::TPU_W'(round % 3));
            round_end = beats_sent + 140;
            while (beats_sent < round_end) begin
                sender_gaps_on  = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) != 0) begin
                    issue_command(i2cmbe_pkg::KIND_START, 8'($urandom), 1'($urandom));
                    n_bytes = $urandom_range(1, 3);
                    repeat (n_bytes) begin
                        if ($urandom_range(0, 1) == 1)
                            issue_command(i2cmbe_pkg::KIND_WRITE, 8'($urandom),
                                          1'($urandom));
                        else
                            issue_command(i2cmbe_pkg::KIND_READ, 8'($urandom),
                                          1'($urandom));
                    end
                    issue_command(i2cmbe_pkg::KIND_STOP, 8'($urandom), 1'($urandom));
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_tick(3'($urandom_range(0, 7)), 8'($urandom),
                                  1'($urandom), 1'($urandom));
                    finish_command();
                end
                if ($urandom_range(0, 9) == 0) wait_results_drained();
            end
        end
        sender_gaps_on  = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_delay();
        test_directed_commands();
        test_long_delay();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d input beats checked against %0d output beats, %0d commands",
                 beats_sent, beats_checked, commands_done);
        $display("summary: %0d delay-unit writes, %0d mismatches, %0d unpredicted beats",
                 tpu_settings, mismatches, orphan_beats);
        if (mismatches == 0 && orphan_beats == 0 && expected_levels.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
